[rtl/rnti_pkg.sv]
package rnti_pkg;

    // Field widths fixed by the interface.
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 31;
    localparam int COUNT_W  = 16;
    localparam int RUN_W    = 3;
    localparam int WEIGHT_W = 10;

    localparam logic [VALUE_W-1:0]  VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [RUN_W-1:0]    RUN_MAX   = {RUN_W{1'b1}};
    localparam logic [RUN_W-1:0]    RUN_LIMIT = 3'd4;

    // ASCII case mask, letter bounds and upper-case digit letters used for decoding.
    localparam logic [CHAR_W-1:0] ASCII_CASE_MASK = 8'hDF;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_I         = 8'h49;
    localparam logic [CHAR_W-1:0] ASCII_V         = 8'h56;
    localparam logic [CHAR_W-1:0] ASCII_X         = 8'h58;
    localparam logic [CHAR_W-1:0] ASCII_L         = 8'h4C;
    localparam logic [CHAR_W-1:0] ASCII_C         = 8'h43;
    localparam logic [CHAR_W-1:0] ASCII_D         = 8'h44;
    localparam logic [CHAR_W-1:0] ASCII_M         = 8'h4D;

    // Digit codes, ordered by weight so that a plain compare orders digits.
    typedef enum logic [2:0] {
        DIGIT_NONE = 3'd0,
        DIGIT_I    = 3'd1,
        DIGIT_V    = 3'd2,
        DIGIT_X    = 3'd3,
        DIGIT_L    = 3'd4,
        DIGIT_C    = 3'd5,
        DIGIT_D    = 3'd6,
        DIGIT_M    = 3'd7
    } digit_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Conversion state carried between bytes.
    typedef struct packed {
        logic                pending_valid;
        digit_t              pending_code;
        digit_t              previous_code;
        logic [RUN_W-1:0]    run_count;
        logic [VALUE_W-1:0]  accumulator;
        logic [COUNT_W-1:0]  letter_count;
        status_t             error_seen;
    } numeral_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] numeral_value;
        logic [COUNT_W-1:0] letters_used;
        status_t            status;
    } result_t;

    // Weight of each digit.
    function automatic logic [WEIGHT_W-1:0] digit_weight(input digit_t d);
        logic [WEIGHT_W-1:0] w;
        unique case (d)
            DIGIT_NONE: w = 10'd0;
            DIGIT_I:    w = 10'd1;
            DIGIT_V:    w = 10'd5;
            DIGIT_X:    w = 10'd10;
            DIGIT_L:    w = 10'd50;
            DIGIT_C:    w = 10'd100;
            DIGIT_D:    w = 10'd500;
            DIGIT_M:    w = 10'd1000;
            default:    w = 10'd0;
        endcase
        return w;
    endfunction

    // Decode a byte to a digit, ignoring case. Other bytes give DIGIT_NONE.
    function automatic digit_t digit_of(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] u;
        digit_t            d;
        u = b & ASCII_CASE_MASK;
        unique case (u)
            ASCII_I: d = DIGIT_I;
            ASCII_V: d = DIGIT_V;
            ASCII_X: d = DIGIT_X;
            ASCII_L: d = DIGIT_L;
            ASCII_C: d = DIGIT_C;
            ASCII_D: d = DIGIT_D;
            ASCII_M: d = DIGIT_M;
            default: d = DIGIT_NONE;
        endcase
        return d;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] b);
        return ((b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) ||
               ((b >= ASCII_LOWER_A) && (b <= ASCII_LOWER_Z));
    endfunction

endpackage

[rtl/rnti_step.sv]
module rnti_step
    import rnti_pkg::*;
(
    input  numeral_state_t     cur_state,
    input  logic [CHAR_W-1:0]  char_code,
    output numeral_state_t     next_state,
    output logic               terminator,
    output result_t            result
);

    logic                 letter;
    digit_t               digit;
    logic                 pair;
    logic [WEIGHT_W-1:0]  pending_weight;
    logic [WEIGHT_W-1:0]  add_operand;
    logic [VALUE_W:0]     sum;
    logic                 sum_over;
    logic [VALUE_W-1:0]   acc_added;
    status_t              err_pair;
    status_t              err_added;
    logic [RUN_W-1:0]     run_next;
    logic                 run_invalid;
    logic                 same_digit;

    // Classify the byte and detect a subtractive pair.
    assign letter         = is_letter(char_code);
    assign digit          = digit_of(char_code);
    assign terminator     = !letter;
    assign pair           = letter && cur_state.pending_valid &&
                            (digit > cur_state.pending_code);
    assign pending_weight = digit_weight(cur_state.pending_code);

    // One shared saturating adder: the pair difference, the settled weight of the
    // pending digit, or zero when no digit is pending.
    always_comb begin
        if (pair) begin
            add_operand = digit_weight(digit) - pending_weight;
        end else if (cur_state.pending_valid) begin
            add_operand = pending_weight;
        end else begin
            add_operand = '0;
        end
    end

    assign sum       = {1'b0, cur_state.accumulator} + (VALUE_W+1)'(add_operand);
    assign sum_over  = sum[VALUE_W];
    assign acc_added = sum_over ? VALUE_MAX : sum[VALUE_W-1:0];

    // A repeated digit in front of a greater one is invalid.
    assign err_pair = (pair && (cur_state.run_count > 3'd1)) ? STATUS_INVALID
                                                            : cur_state.error_seen;
    assign err_added = (sum_over && (err_pair != STATUS_INVALID)) ? STATUS_OVERFLOW
                                                                  : err_pair;

    // Run length of the current digit and the repeat rules.
    assign same_digit = (digit == cur_state.previous_code);
    always_comb begin
        if (same_digit) begin
            run_next = (cur_state.run_count < RUN_MAX) ? cur_state.run_count + 3'd1
                                                       : RUN_MAX;
        end else begin
            run_next = 3'd1;
        end
    end
    assign run_invalid = same_digit &&
                         (((run_next > RUN_LIMIT) && (digit != DIGIT_M)) ||
                          ((run_next > 3'd1) &&
                           ((digit == DIGIT_V) || (digit == DIGIT_L) ||
                            (digit == DIGIT_D))));

    // Result of a terminator.
    always_comb begin
        result.numeral_value = (err_added == STATUS_INVALID) ? '0 : acc_added;
        result.letters_used  = cur_state.letter_count;
        result.status        = err_added;
    end

    // State update.
    always_comb begin
        next_state = cur_state;
        if (!letter) begin
            next_state = '0;
        end else begin
            next_state.letter_count = (cur_state.letter_count < COUNT_MAX) ?
                                      cur_state.letter_count + 16'd1 : COUNT_MAX;
            next_state.accumulator   = acc_added;
            next_state.pending_valid = 1'b0;
            if (pair) begin
                next_state.error_seen = err_added;
            end else begin
                next_state.error_seen    = run_invalid ? STATUS_INVALID : err_added;
                next_state.run_count     = run_next;
                next_state.previous_code = digit;
                if (digit != DIGIT_NONE) begin
                    next_state.pending_valid = 1'b1;
                    next_state.pending_code  = digit;
                end
            end
        end
    end

endmodule

[rtl/roman_numeral_to_integer_top.sv]
// A result is registered in the output register, or in the skid entry when full.
// Throughput: one byte per cycle while s_ready is high, with a combinational step.
// A two-entry output stage (result register plus skid) keeps input flowing while
// a result waits; s_ready drops only when both entries hold results.
// Reset: synchronous, active-low aresetn clears the conversion state and both entries.
module roman_numeral_to_integer_top
    import rnti_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAR_W-1:0]   s_char_code,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_numeral_value,
    output logic [COUNT_W-1:0]  m_letters_used,
    output logic [1:0]          m_status
);

    numeral_state_t state_reg;
    numeral_state_t state_next;
    numeral_state_t step_state;
    result_t        step_result;
    logic           step_term;

    result_t        out_reg;
    result_t        skid_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;

    logic           s_fire;
    logic           m_fire;
    logic           push;

    rnti_step u_step (
        .cur_state  (state_reg),
        .char_code  (s_char_code),
        .next_state (step_state),
        .terminator (step_term),
        .result     (step_result)
    );

    // Handshake decode.
    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;
    assign push    = s_fire && step_term;

    assign state_next = s_fire ? step_state : state_reg;

    // Conversion state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || m_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || m_fire) begin
                out_reg <= step_result;
            end else begin
                skid_reg <= step_result;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_numeral_value = out_reg.numeral_value;
    assign m_letters_used  = out_reg.letters_used;
    assign m_status        = out_reg.status;

`ifndef NO_ASSERTIONS
    // The skid entry is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // An invalid numeral always reports value zero.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_INVALID)) |-> (m_numeral_value == '0))
        else $error("invalid numeral reported a nonzero value");

    // An overflow always reports the saturated value.
    a_overflow_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_OVERFLOW)) |-> (m_numeral_value == VALUE_MAX))
        else $error("overflow reported without a saturated value");

    // A terminator clears the conversion state.
    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> ((state_reg.accumulator == '0) && (state_reg.letter_count == '0) &&
                  !state_reg.pending_valid))
        else $error("conversion state not cleared after a terminator");
`endif

endmodule
